@@ design/epoch_seconds_to_calendar_unit_assert.svh @@
// Assertion macros shared by the epoch-to-calendar RTL.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef EPOCH_SECONDS_TO_CALENDAR_UNIT_ASSERT_SVH
`define EPOCH_SECONDS_TO_CALENDAR_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ES2C_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ES2C_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/es2c_pkg.sv @@
// Package for the epoch-to-calendar unit: constants, the result struct and
// the calendar helper functions. It depends on nothing else.
package es2c_pkg;

  localparam logic [31:0] SECS_PER_DAY      = 32'd86400;
  localparam logic [31:0] SECS_PER_HOUR     = 32'd3600;
  localparam logic [31:0] SECS_PER_MIN      = 32'd60;
  localparam logic [31:0] DAYS_COMMON_YEAR  = 32'd365;
  localparam logic [31:0] DAYS_LEAP_YEAR    = 32'd366;

  // 1970 expressed as years since 1900.
  localparam logic [7:0]  YEAR_FIRST        = 8'd70;
  // 2100 expressed as years since 1900: the only century in range that is not leap.
  localparam logic [7:0]  YEAR_NOLEAP_CENT  = 8'd200;
  localparam logic [3:0]  MONTH_LAST        = 4'd11;

  // Top quotient bit of each long division step.
  localparam logic [3:0]  DAY_TOP_BIT       = 4'd15;
  localparam logic [3:0]  HOUR_TOP_BIT      = 4'd4;
  localparam logic [3:0]  MIN_TOP_BIT       = 4'd5;

  typedef struct packed {
    logic [5:0] second_of_minute;
    logic [5:0] minute_of_hour;
    logic [4:0] hour_of_day;
    logic [7:0] years_since_1900;
    logic [3:0] month_index;
    logic [4:0] day_of_month;
  } calendar_t;

  // Years since 1900 cover 1970 to 2106. 1900 is a multiple of 4, so the low two
  // bits decide; 2000 is a leap century and 2100 is not.
  function automatic logic is_leap(input logic [7:0] yr);
    return (yr[1:0] == 2'b00) && (yr != YEAR_NOLEAP_CENT);
  endfunction

  function automatic logic [4:0] month_len(input logic leap, input logic [3:0] mon);
    logic [4:0] len;
    case (mon)
      4'd1:    len = leap ? 5'd29 : 5'd28;
      4'd3:    len = 5'd30;
      4'd5:    len = 5'd30;
      4'd8:    len = 5'd30;
      4'd10:   len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

@@ design/es2c_sub.sv @@
// Shared compare-and-subtract unit of the epoch-to-calendar sequencer.
// Stand-alone; it uses nothing from the package.
module es2c_sub (
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [31:0] diff,
  output logic        ge
);

  logic borrow;

  assign {borrow, diff} = {1'b0, a} - {1'b0, b};
  assign ge = ~borrow;

endmodule

@@ design/es2c_core.sv @@
// Sequencer and working registers of the epoch-to-calendar unit.
// Depends on es2c_pkg, es2c_sub and the assertion macro header.
`include "epoch_seconds_to_calendar_unit_assert.svh"

module es2c_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [31:0]         secs,
  input  logic                drain,
  output logic                idle,
  output logic                done,
  output es2c_pkg::calendar_t res
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_DAY   = 7'b0000010,
    S_HOUR  = 7'b0000100,
    S_MIN   = 7'b0001000,
    S_YEAR  = 7'b0010000,
    S_MONTH = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t      state_r, state_nxt;
  logic [31:0] a_r, a_nxt;
  logic [15:0] days_r, days_nxt;
  logic [3:0]  k_r, k_nxt;
  logic [4:0]  hour_r, hour_nxt;
  logic [5:0]  min_r, min_nxt;
  logic [5:0]  sec_r, sec_nxt;
  logic [7:0]  year_r, year_nxt;
  logic [3:0]  month_r, month_nxt;

  logic [31:0] sub_b;
  logic [31:0] sub_diff;
  logic        sub_ge;
  logic        leap;

  assign leap = es2c_pkg::is_leap(year_r);

  es2c_sub u_sub (
    .a    (a_r),
    .b    (sub_b),
    .diff (sub_diff),
    .ge   (sub_ge)
  );

  always_comb begin
    state_nxt = state_r;
    a_nxt     = a_r;
    days_nxt  = days_r;
    k_nxt     = k_r;
    hour_nxt  = hour_r;
    min_nxt   = min_r;
    sec_nxt   = sec_r;
    year_nxt  = year_r;
    month_nxt = month_r;
    sub_b     = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          a_nxt     = secs;
          days_nxt  = '0;
          hour_nxt  = '0;
          min_nxt   = '0;
          k_nxt     = es2c_pkg::DAY_TOP_BIT;
          state_nxt = S_DAY;
        end
      end
      S_DAY: begin
        sub_b = es2c_pkg::SECS_PER_DAY << k_r;
        if (sub_ge) begin
          a_nxt    = sub_diff;
          days_nxt = days_r | (16'd1 << k_r);
        end
        if (k_r == 4'd0) begin
          k_nxt     = es2c_pkg::HOUR_TOP_BIT;
          state_nxt = S_HOUR;
        end else begin
          k_nxt = k_r - 4'd1;
        end
      end
      S_HOUR: begin
        sub_b = es2c_pkg::SECS_PER_HOUR << k_r;
        if (sub_ge) begin
          a_nxt    = sub_diff;
          hour_nxt = hour_r | (5'd1 << k_r);
        end
        if (k_r == 4'd0) begin
          k_nxt     = es2c_pkg::MIN_TOP_BIT;
          state_nxt = S_MIN;
        end else begin
          k_nxt = k_r - 4'd1;
        end
      end
      S_MIN: begin
        sub_b = es2c_pkg::SECS_PER_MIN << k_r;
        if (sub_ge) begin
          a_nxt   = sub_diff;
          min_nxt = min_r | (6'd1 << k_r);
        end
        if (k_r == 4'd0) begin
          // The remainder is the second count; the day count moves into the
          // working register for the year loop.
          sec_nxt   = sub_ge ? sub_diff[5:0] : a_r[5:0];
          a_nxt     = {16'd0, days_r};
          year_nxt  = es2c_pkg::YEAR_FIRST;
          state_nxt = S_YEAR;
        end else begin
          k_nxt = k_r - 4'd1;
        end
      end
      S_YEAR: begin
        sub_b = leap ? es2c_pkg::DAYS_LEAP_YEAR : es2c_pkg::DAYS_COMMON_YEAR;
        if (sub_ge) begin
          a_nxt    = sub_diff;
          year_nxt = year_r + 8'd1;
        end else begin
          month_nxt = '0;
          state_nxt = S_MONTH;
        end
      end
      S_MONTH: begin
        sub_b = {27'd0, es2c_pkg::month_len(leap, month_r)};
        if ((month_r != es2c_pkg::MONTH_LAST) && sub_ge) begin
          a_nxt     = sub_diff;
          month_nxt = month_r + 4'd1;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (drain) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r     <= a_nxt;
    days_r  <= days_nxt;
    k_r     <= k_nxt;
    hour_r  <= hour_nxt;
    min_r   <= min_nxt;
    sec_r   <= sec_nxt;
    year_r  <= year_nxt;
    month_r <= month_nxt;
  end

  assign idle = (state_r == S_IDLE);
  assign done = (state_r == S_DONE);

  assign res.second_of_minute = sec_r;
  assign res.minute_of_hour   = min_r;
  assign res.hour_of_day      = hour_r;
  assign res.years_since_1900 = year_r;
  assign res.month_index      = month_r;
  assign res.day_of_month     = a_r[4:0] + 5'd1;

  `ES2C_ASSERT_SAME(a_start_idle, start, state_r == S_IDLE, "request started while busy")
  `ES2C_ASSERT_NEXT(a_min_to_year, (state_r == S_MIN) && (k_r == 4'd0), state_r == S_YEAR, "minute step did not hand over to year loop")
  `ES2C_ASSERT_SAME(a_year_range, state_r == S_YEAR, year_r <= 8'd206, "year count ran past 2106")
  `ES2C_ASSERT_SAME(a_done_range, state_r == S_DONE, (hour_r < 5'd24) && (a_r < 32'd31) && (month_r <= es2c_pkg::MONTH_LAST), "finished result out of range")

endmodule

@@ design/epoch_seconds_to_calendar_unit.sv @@
// Epoch seconds to UTC calendar converter. One request carries a 32-bit count of
// seconds since 1970-01-01 00:00:00 UTC; the result carries second, minute, hour,
// years since 1900, month (0 is January) and day of month (1 to 31). Every input
// value is legal and gives exactly one result. A single 32-bit compare-and-subtract
// unit does all the arithmetic under a small sequencer, one step per cycle: 16 steps
// of long division by 86400, 5 steps for the hour, 6 for the minute, then one step
// per elapsed year plus one (Y + 1, where Y is the year minus 1970) and one step per
// elapsed month plus one (M + 1). in_stall stays high from acceptance until the
// finished result leaves the sequencer. The finished result moves into an output
// register, so the next request is taken while a result still waits on out_stall;
// the sequencer only holds when that register is full and not draining.
// Depends on es2c_pkg and es2c_core.
module epoch_seconds_to_calendar_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_epoch_seconds,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [5:0]  out_second_of_minute,
  output logic [5:0]  out_minute_of_hour,
  output logic [4:0]  out_hour_of_day,
  output logic [7:0]  out_years_since_1900,
  output logic [3:0]  out_month_index,
  output logic [4:0]  out_day_of_month
);

  logic                core_idle;
  logic                core_done;
  logic                core_drain;
  logic                start;
  es2c_pkg::calendar_t core_res;
  es2c_pkg::calendar_t res_r;
  logic                out_valid_r;

  // The sequencer takes a new request only from its idle state.
  assign in_stall = ~core_idle;
  assign start    = in_valid & core_idle;

  // A finished result moves out when the output register is empty or being taken.
  assign core_drain = core_done & (~out_valid_r | ~out_stall);

  es2c_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .secs  (in_epoch_seconds),
    .drain (core_drain),
    .idle  (core_idle),
    .done  (core_done),
    .res   (core_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (core_drain) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (core_drain) begin
      res_r <= core_res;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_second_of_minute = res_r.second_of_minute;
  assign out_minute_of_hour   = res_r.minute_of_hour;
  assign out_hour_of_day      = res_r.hour_of_day;
  assign out_years_since_1900 = res_r.years_since_1900;
  assign out_month_index      = res_r.month_index;
  assign out_day_of_month     = res_r.day_of_month;

endmodule
